// ===== hdl/pmid_pkg.sv =====
// Shared constants and register codes for the periodic minimum-image distance block.
// No dependencies; every other file imports this package.
package pmid_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 24;
  localparam int unsigned BOX_WIDTH       = 23;
  localparam int unsigned AXES_WIDTH      = 3;
  localparam int unsigned CFG_IDX_WIDTH   = 2;
  localparam int unsigned CFG_DATA_WIDTH  = 23;

  localparam logic [BOX_WIDTH-1:0]  BOX_RESET  = 23'd4194304;
  localparam logic [AXES_WIDTH-1:0] AXES_RESET = 3'd7;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_BOX_X = 2'd0,
    REG_BOX_Y = 2'd1,
    REG_BOX_Z = 2'd2,
    REG_AXES  = 2'd3
  } cfg_reg_e;

endpackage

// ===== hdl/pmid_if.sv =====
// Valid/ready channel interfaces for point pairs and distance results.
// Depends on pmid_pkg for the default coordinate width.
interface pmid_pair_if import pmid_pkg::*; #(
  parameter int unsigned CW = COORD_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] first_x;
  logic signed [CW-1:0] first_y;
  logic signed [CW-1:0] first_z;
  logic signed [CW-1:0] second_x;
  logic signed [CW-1:0] second_y;
  logic signed [CW-1:0] second_z;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
    output ready
  );
endinterface

interface pmid_res_if import pmid_pkg::*; #(
  parameter int unsigned CW = COORD_WIDTH_DEF
) ();
  logic               valid;
  logic               ready;
  logic signed [CW:0] disp_x;
  logic signed [CW:0] disp_y;
  logic signed [CW:0] disp_z;
  logic        [CW:0] dist_res;

  modport source (
    output valid, disp_x, disp_y, disp_z, dist_res,
    input  ready
  );
  modport sink (
    input  valid, disp_x, disp_y, disp_z, dist_res,
    output ready
  );
endinterface

// ===== hdl/periodic_min_image_distance.sv =====
// Periodic minimum-image displacement and floor-sqrt distance, fully pipelined.
// Square-root section: R = min(COORD_WIDTH + 1, 32) restoring square-root stages;
// throughput one transaction per cycle while res_o.ready does not stall the output.
// Each stage holds its own valid bit, so bubbles collapse under output stall.
// Reset clears the valid bits and loads box lengths of 4194304 (2^22) with all axes periodic.
// Depends on pmid_pkg and pmid_if.
module periodic_min_image_distance import pmid_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data_i,
  pmid_pair_if.sink                 pair_i,
  pmid_res_if.source                res_o
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned OW   = CW + 1;
  localparam int unsigned CMPW = (CW + 2 > BOX_WIDTH + 1) ? CW + 2 : BOX_WIDTH + 1;
  localparam int unsigned SUMW = 2 * CW + 2;
  localparam int unsigned RW   = (SUMW > 64) ? 64 : SUMW;
  localparam int unsigned RB   = RW / 2;
  localparam int unsigned REMW = RB + 2;
  localparam int unsigned NS   = 4 + RB;

  logic [BOX_WIDTH-1:0]  box_x_q, box_y_q, box_z_q;
  logic [AXES_WIDTH-1:0] axes_q;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  logic signed [OW-1:0] dx_q [NS];
  logic signed [OW-1:0] dy_q [NS];
  logic signed [OW-1:0] dz_q [NS];

  logic [2*CW-1:0] sqx_q, sqy_q, sqz_q;
  logic [SUMW-1:0] sum_full;
  logic [RW-1:0]   sum_sat;

  logic [RW-1:0]   n_q    [RB+1];
  logic [REMW-1:0] rem_q  [RB+1];
  logic [RB-1:0]   root_q [RB+1];

  function automatic logic signed [OW-1:0] wrap_axis(
    input logic signed [OW-1:0]  d,
    input logic [BOX_WIDTH-1:0]  box,
    input logic                  wrap_en
  );
    logic signed [CMPW-1:0] dw;
    logic signed [CMPW-1:0] d2;
    logic signed [CMPW-1:0] bs;
    logic signed [CMPW-1:0] r;
    dw = CMPW'(d);
    d2 = dw <<< 1;
    bs = signed'(CMPW'(box));
    r  = dw;
    if (wrap_en && (d2 > bs)) begin
      r = dw - bs;
    end else if (wrap_en && (d2 < -bs)) begin
      r = dw + bs;
    end
    return signed'(r[OW-1:0]);
  endfunction

  function automatic logic [CW-1:0] mag(input logic signed [OW-1:0] d);
    logic signed [OW-1:0] neg;
    neg = -d;
    return d[OW-1] ? neg[CW-1:0] : d[CW-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q <= BOX_RESET;
      box_y_q <= BOX_RESET;
      box_z_q <= BOX_RESET;
      axes_q  <= AXES_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BOX_X: box_x_q <= cfg_data_i[BOX_WIDTH-1:0];
        REG_BOX_Y: box_y_q <= cfg_data_i[BOX_WIDTH-1:0];
        REG_BOX_Z: box_z_q <= cfg_data_i[BOX_WIDTH-1:0];
        REG_AXES:  axes_q  <= cfg_data_i[AXES_WIDTH-1:0];
        default:   axes_q  <= axes_q;
      endcase
    end
  end

  // advance a stage when it is empty or its successor advances
  assign en[NS-1] = !vld_q[NS-1] || res_o.ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  assign pair_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= pair_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage 0: raw differences
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dx_q[0] <= OW'(pair_i.second_x) - OW'(pair_i.first_x);
      dy_q[0] <= OW'(pair_i.second_y) - OW'(pair_i.first_y);
      dz_q[0] <= OW'(pair_i.second_z) - OW'(pair_i.first_z);
    end
  end

  // stage 1 wraps, later stages carry the displacement along
  for (genvar k = 1; k < NS; k++) begin : g_disp
    if (k == 1) begin : g_wrap
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          dx_q[k] <= wrap_axis(dx_q[k-1], box_x_q, axes_q[0]);
          dy_q[k] <= wrap_axis(dy_q[k-1], box_y_q, axes_q[1]);
          dz_q[k] <= wrap_axis(dz_q[k-1], box_z_q, axes_q[2]);
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          dx_q[k] <= dx_q[k-1];
          dy_q[k] <= dy_q[k-1];
          dz_q[k] <= dz_q[k-1];
        end
      end
    end
  end

  // stage 2: squares
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sqx_q <= (2*CW)'(mag(dx_q[1])) * (2*CW)'(mag(dx_q[1]));
      sqy_q <= (2*CW)'(mag(dy_q[1])) * (2*CW)'(mag(dy_q[1]));
      sqz_q <= (2*CW)'(mag(dz_q[1])) * (2*CW)'(mag(dz_q[1]));
    end
  end

  // stage 3: sum of squares, saturating when SUMW exceeds RW
  assign sum_full = SUMW'(sqx_q) + SUMW'(sqy_q) + SUMW'(sqz_q);

  if (SUMW > RW) begin : g_sat
    assign sum_sat = (|sum_full[SUMW-1:RW]) ? '1 : sum_full[RW-1:0];
  end else begin : g_nosat
    assign sum_sat = sum_full[RW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      n_q[0]    <= sum_sat;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  // square-root stages: one root bit each
  for (genvar j = 1; j <= RB; j++) begin : g_sqrt
    logic [REMW-1:0] cur;
    logic [REMW-1:0] trial;
    logic            take;

    assign cur   = {rem_q[j-1][REMW-3:0], n_q[j-1][RW-1 -: 2]};
    assign trial = {root_q[j-1], 2'b01};
    assign take  = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en[3+j]) begin
        n_q[j]    <= n_q[j-1] << 2;
        rem_q[j]  <= take ? (cur - trial) : cur;
        root_q[j] <= {root_q[j-1][RB-2:0], take};
      end
    end
  end

  assign res_o.valid    = vld_q[NS-1];
  assign res_o.disp_x   = dx_q[NS-1];
  assign res_o.disp_y   = dy_q[NS-1];
  assign res_o.disp_z   = dz_q[NS-1];
  assign res_o.dist_res = OW'(root_q[RB]);

endmodule
